// ===== rtl/bpbq_pkg.sv =====
// Package for the band-pass biquad cascade power meter.
// Holds sizes, register indexes, the sequencer state type, divider handshake
// structs and the saturation helpers. No dependencies.
package bpbq_pkg;

  localparam int SECTIONS       = 4;
  localparam int MAX_SEGMENT    = 1024;

  localparam int SAMPLE_W       = 16;
  localparam int COEF_W         = 32;
  localparam int SIG_W          = 32;
  localparam int PROD_W         = 2 * SIG_W;
  localparam int ACC_W          = 64;
  localparam int SUM_W          = 64;
  localparam int POWER_W        = 32;
  localparam int SAMPLE_COUNT_W = 11;
  localparam int CFG_IDX_W      = 2;
  localparam int CNT_W          = $clog2(MAX_SEGMENT + 1);
  localparam int SEC_AW         = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int ITER_W         = $clog2(SUM_W);
  localparam int ROW_W          = 2 * SIG_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_B0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_A1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_A2 = 2'd2;

  localparam logic signed [ACC_W:0] ACC_LIM    = 65'sd1 <<< 61;
  localparam logic signed [ACC_W:0] SIG_MAX    = 65'sd2147483647;
  localparam logic signed [ACC_W:0] SIG_MIN    = -65'sd2147483648;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = 64'sd1 <<< 27;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_ACC,
    ST_WB,
    ST_SQ,
    ST_SUM,
    ST_DIV
  } st_e;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

  // Clamp a wide partial sum to +-2^61.
  function automatic logic signed [ACC_W-1:0] clamp_acc(logic signed [ACC_W:0] v);
    logic signed [ACC_W:0] r;
    r = v;
    if (v > ACC_LIM) r = ACC_LIM;
    if (v < -ACC_LIM) r = -ACC_LIM;
    return ACC_W'(r);
  endfunction

  // Saturate to the signed 32-bit signal range.
  function automatic logic signed [SIG_W-1:0] sat_sig(logic signed [ACC_W:0] v);
    logic signed [ACC_W:0] r;
    r = v;
    if (v > SIG_MAX) r = SIG_MAX;
    if (v < SIG_MIN) r = SIG_MIN;
    return SIG_W'(r);
  endfunction

endpackage

// ===== rtl/bpbq_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Divides the 64-bit square sum by the segment count; uses bpbq_pkg.
module bpbq_div
  import bpbq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [SUM_W-1:0]  dq_q, dq_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  dvs_q;
  logic [ITER_W-1:0] iter_q;
  logic              busy_q, done_q;
  logic [CNT_W:0]    shifted, trial;

  always_comb begin
    shifted = {rem_q, dq_q[SUM_W-1]};
    trial   = shifted - {1'b0, dvs_q};
    if (!trial[CNT_W]) begin
      rem_d = trial[CNT_W-1:0];
      dq_d  = {dq_q[SUM_W-2:0], 1'b1};
    end else begin
      rem_d = shifted[CNT_W-1:0];
      dq_d  = {dq_q[SUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      iter_q <= '0;
    end else if (busy_q) begin
      iter_q <= iter_q + 1'b1;
      if (iter_q == ITER_W'(SUM_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dq_q  <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dq_q;

endmodule

// ===== rtl/bandpass_biquad_cascade_power_core.sv =====
// Top level of the band-pass biquad cascade power meter.
// Sequencer, history memories, shared multiplier and accumulator; uses bpbq_pkg
// and bpbq_div.

// Each sample runs through SECTIONS band-pass biquads (b1 = 0, b2 = -b0,
// Q4.28 coefficients, Q24.8 signal), one section after another on a single
// shared 32x32 multiplier. The final output is squared and summed; on a
// sample marked last, or when the segment reaches MAX_SEGMENT samples, the
// block emits floor(sum / count / 65536) saturated to 32 bits, with the count,
// and clears all history, the sum and the count. The block takes no new sample
// until the one before it has run through all sections and been summed, since
// the multiplier is shared; a closing sample also waits for the bit-serial
// divider and, if needed, for the output register to drain. History lives in
// two one-row-per-section memories with a registered read; a valid bit per row
// stands in for the zero after reset and after each segment, so no clearing
// pass is needed. Write coefficients only while the block is idle.
module bandpass_biquad_cascade_power_core
  import bpbq_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [COEF_W-1:0]         cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                      last_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [POWER_W-1:0]        power_o,
  output logic [SAMPLE_COUNT_W-1:0] sample_count_o
);

  // Coefficients
  logic signed [COEF_W-1:0] b0_q, a1_q, a2_q;

  // Sequencer
  st_e               st_q, st_d;
  logic [SEC_AW-1:0] k_q;
  logic              k_last;

  // History memories: row k holds {h0, h1} of section k
  logic [ROW_W-1:0]    x_mem [SECTIONS];
  logic [ROW_W-1:0]    y_mem [SECTIONS];
  logic [ROW_W-1:0]    xrow_q, yrow_q;
  logic                rvld_q;
  logic [SECTIONS-1:0] row_vld_q;
  logic                rd_en, wr_en;
  logic [SEC_AW-1:0]   rd_addr;

  // Datapath
  logic signed [SIG_W-1:0]  x_q;
  logic                     fin_q;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [SIG_W-1:0]  mul_a, mul_b;
  logic signed [SIG_W-1:0]  h_x1, h_x2, h_y1, h_y2;
  logic signed [SIG_W-1:0]  diff, y_new;
  logic signed [ACC_W:0]    acc_m_prod;
  logic [SUM_W-1:0]         sum_q, sum_sat;
  logic [SUM_W:0]           sum_ext;
  logic [CNT_W-1:0]         seen_q, cnt_inc;
  logic                     fin_now;

  // Output side
  logic                      out_valid_q;
  logic [POWER_W-1:0]        power_q;
  logic [SAMPLE_COUNT_W-1:0] count_q, count_res_q;
  logic                      out_free, out_load;
  logic [POWER_W-1:0]        power_sat;

  div_req_t div_req;
  div_rsp_t div_rsp;

  bpbq_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Coefficient writes; indexes past the list drop silently
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q <= '0;
      a1_q <= '0;
      a2_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_B0:  b0_q <= cfg_data_i;
        CFG_A1:  a1_q <= cfg_data_i;
        CFG_A2:  a2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // History values, zero for rows not written since the last clear
  assign h_x1 = rvld_q ? xrow_q[ROW_W-1:SIG_W] : '0;
  assign h_x2 = rvld_q ? xrow_q[SIG_W-1:0]     : '0;
  assign h_y1 = rvld_q ? yrow_q[ROW_W-1:SIG_W] : '0;
  assign h_y2 = rvld_q ? yrow_q[SIG_W-1:0]     : '0;

  assign k_last     = (k_q == SEC_AW'(SECTIONS - 1));
  assign diff       = sat_sig({{(ACC_W-SIG_W+1){x_q[SIG_W-1]}}, x_q}
                            - {{(ACC_W-SIG_W+1){h_x2[SIG_W-1]}}, h_x2});
  assign acc_m_prod = {acc_q[ACC_W-1], acc_q} - {prod_q[PROD_W-1], prod_q};
  // Arithmetic shift right by 28, sign-extended to the 65-bit saturator input
  assign y_new      = sat_sig({{29{acc_q[ACC_W-1]}}, acc_q[ACC_W-1:28]});

  // Square sum with saturation at all ones; square of a 32-bit value is >= 0
  assign sum_ext = {1'b0, sum_q} + {1'b0, prod_q};
  assign sum_sat = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
  assign cnt_inc = seen_q + 1'b1;
  assign fin_now = fin_q || (cnt_inc >= CNT_W'(MAX_SEGMENT));

  assign out_free  = !out_valid_q || out_ready_i;
  assign power_sat = (div_rsp.quotient[SUM_W-1:POWER_W+16] != '0) ? '1
                   : div_rsp.quotient[POWER_W+15:16];

  // Next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (in_valid_i) st_d = ST_MUL0;
      ST_MUL0: st_d = ST_MUL1;
      ST_MUL1: st_d = ST_MUL2;
      ST_MUL2: st_d = ST_ACC;
      ST_ACC:  st_d = ST_WB;
      ST_WB:   st_d = k_last ? ST_SQ : ST_MUL0;
      ST_SQ:   st_d = ST_SUM;
      ST_SUM:  st_d = fin_now ? ST_DIV : ST_IDLE;
      ST_DIV:  if (div_rsp.done && out_free) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready_o       = 1'b0;
    rd_en            = 1'b0;
    rd_addr          = '0;
    wr_en            = 1'b0;
    mul_a            = '0;
    mul_b            = '0;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = sum_sat;
    div_req.divisor  = cnt_inc;
    case (st_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        rd_en      = in_valid_i;
      end
      ST_MUL0: begin
        mul_a = b0_q;
        mul_b = diff;
      end
      ST_MUL1: begin
        mul_a = a1_q;
        mul_b = h_y1;
      end
      ST_MUL2: begin
        mul_a = a2_q;
        mul_b = h_y2;
      end
      ST_WB: begin
        wr_en   = 1'b1;
        rd_en   = !k_last;
        rd_addr = k_q + 1'b1;
      end
      ST_SQ: begin
        mul_a = x_q;
        mul_b = x_q;
      end
      ST_SUM:  div_req.start = fin_now;
      ST_DIV:  out_load = div_rsp.done && out_free;
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // History memories: synchronous read, write back at the end of a section
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      xrow_q <= x_mem[rd_addr];
      yrow_q <= y_mem[rd_addr];
    end
    if (wr_en) begin
      x_mem[k_q] <= {x_q, h_x1};
      y_mem[k_q] <= {y_new, h_y1};
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      k_q         <= '0;
      row_vld_q   <= '0;
      rvld_q      <= 1'b0;
      sum_q       <= '0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (rd_en) rvld_q <= row_vld_q[rd_addr];
      if (st_q == ST_IDLE) k_q <= '0;
      if (wr_en) begin
        row_vld_q[k_q] <= 1'b1;
        k_q            <= k_q + 1'b1;
      end
      if (st_q == ST_SUM) begin
        // Close the segment: drop history, sum and count
        if (fin_now) begin
          row_vld_q <= '0;
          sum_q     <= '0;
          seen_q    <= '0;
        end else begin
          sum_q  <= sum_sat;
          seen_q <= cnt_inc;
        end
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (st_q == ST_IDLE && in_valid_i) begin
      x_q   <= SIG_W'({{(SIG_W-SAMPLE_W){sample_i[SAMPLE_W-1]}}, sample_i} <<< 8);
      fin_q <= last_i;
    end
    case (st_q)
      ST_MUL1: acc_q <= prod_q;
      ST_MUL2: acc_q <= clamp_acc(acc_m_prod);
      ST_ACC:  acc_q <= clamp_acc(acc_m_prod) + ROUND_HALF;
      default: ;
    endcase
    if (wr_en) x_q <= y_new;
    if (st_q == ST_SUM && fin_now) count_res_q <= SAMPLE_COUNT_W'(cnt_inc);
    if (out_load) begin
      power_q <= power_sat;
      count_q <= count_res_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign power_o        = power_q;
  assign sample_count_o = count_q;

endmodule

// ===== dv/tb_bandpass_biquad_cascade_power_core.sv =====
// Self-checking testbench for bandpass_biquad_cascade_power_core.
// Predicts each segment's mean-square power with a cycle-free model of the cascade.
// Depends on bpbq_pkg and the core RTL only.
module tb_bandpass_biquad_cascade_power_core;
  import bpbq_pkg::*;

  // Cycles to let a sample finish after the last result, plus margin.
  localparam int DRAIN_CYCLES    = 120;
  // Longest run without any transfer before the run is declared hung.
  localparam int WATCHDOG_LIMIT  = 5000;
  // Long receiver hold-off that backs the core up into its input.
  localparam int HOLD_OFF_CYCLES = 1500;

  // Register index with no register behind it; the core must ignore it.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // Q4.28 coefficient sets.
  localparam logic [COEF_W-1:0] BP_B0    = 32'sd18119393;    //  0.0675
  localparam logic [COEF_W-1:0] BP_A1    = -32'sd483183821;  // -1.8
  localparam logic [COEF_W-1:0] BP_A2    = 32'sd232196669;   //  0.865
  localparam logic [COEF_W-1:0] NB_A1    = -32'sd510027366;  // -1.9
  localparam logic [COEF_W-1:0] NB_A2    = 32'sd255013683;   //  0.95
  localparam logic [COEF_W-1:0] COEF_MAX = 32'h7FFF_FFFF;
  localparam logic [COEF_W-1:0] COEF_MIN = 32'h8000_0000;
  localparam logic [COEF_W-1:0] COEF_ZERO = '0;

  typedef enum int {SMP_FULL, SMP_SMALL, SMP_EXTREME, SMP_WALK} sample_kind_e;
  typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_SLOW} rx_mode_e;

  typedef struct packed {
    logic [POWER_W-1:0]        power;
    logic [SAMPLE_COUNT_W-1:0] sample_count;
  } power_result_t;

  // Tracks coefficients, filter history and the running square sum, and holds
  // the power results still owed by the core.
  class power_meter_tracker;
    logic signed [COEF_W-1:0] b0, a1, a2;
    logic signed [SIG_W-1:0]  x_hist [SECTIONS][2];
    logic signed [SIG_W-1:0]  y_hist [SECTIONS][2];
    logic [SUM_W-1:0]         square_acc;
    int unsigned              seg_len;
    power_result_t            owed_powers[$];
    int                       errors;
    int                       results_checked;

    function new();
      b0 = '0;
      a1 = '0;
      a2 = '0;
      errors = 0;
      results_checked = 0;
      clear_segment();
    endfunction

    function void clear_segment();
      for (int k = 0; k < SECTIONS; k++) begin
        x_hist[k][0] = '0;
        x_hist[k][1] = '0;
        y_hist[k][0] = '0;
        y_hist[k][1] = '0;
      end
      square_acc = '0;
      seg_len = 0;
    endfunction

    function void write_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
      case (idx)
        CFG_B0: b0 = val;
        CFG_A1: a1 = val;
        CFG_A2: a2 = val;
        default: ;
      endcase
    endfunction

    function logic signed [SIG_W-1:0] clamp_sig(logic signed [79:0] v);
      if (v > SIG_MAX) return SIG_MAX[SIG_W-1:0];
      if (v < SIG_MIN) return SIG_MIN[SIG_W-1:0];
      return v[SIG_W-1:0];
    endfunction

    function logic signed [79:0] clamp_partial(logic signed [79:0] v);
      if (v > ACC_LIM) return ACC_LIM;
      if (v < -ACC_LIM) return -ACC_LIM;
      return v;
    endfunction

    // One direct-form-I section: y = b0*(x - x2) - a1*y1 - a2*y2, round half up.
    function logic signed [SIG_W-1:0] run_biquad(int k, logic signed [SIG_W-1:0] x);
      logic signed [79:0]      diff;
      logic signed [79:0]      acc;
      logic signed [SIG_W-1:0] dsat;
      logic signed [SIG_W-1:0] y;
      diff = x - x_hist[k][1];
      dsat = clamp_sig(diff);
      acc  = b0 * dsat - a1 * y_hist[k][0];
      acc  = clamp_partial(acc);
      acc  = clamp_partial(acc - a2 * y_hist[k][1]) + (80'sd1 <<< 27);
      y    = clamp_sig(acc >>> 28);
      x_hist[k][1] = x_hist[k][0];
      x_hist[k][0] = x;
      y_hist[k][1] = y_hist[k][0];
      y_hist[k][0] = y;
      return y;
    endfunction

    function int owed();
      return owed_powers.size();
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] s, logic lst);
      logic signed [SIG_W-1:0] v;
      logic signed [63:0]      yw;
      logic [SUM_W-1:0]        sq;
      logic [SUM_W:0]          total;
      logic [SUM_W-1:0]        q;
      int unsigned             cnt;
      power_result_t           r;
      v = s;
      v = v <<< 8;
      for (int k = 0; k < SECTIONS; k++) v = run_biquad(k, v);
      yw = v;
      sq = yw * yw;
      total = square_acc + sq;
      square_acc = total[SUM_W] ? '1 : total[SUM_W-1:0];
      cnt = seg_len + 1;
      // A full-length segment closes itself even without the last flag.
      if (!lst && cnt < MAX_SEGMENT) begin
        seg_len = cnt;
        return;
      end
      q = (square_acc / cnt) >> 16;
      r.power = (q > 64'hFFFF_FFFF) ? '1 : q[POWER_W-1:0];
      r.sample_count = SAMPLE_COUNT_W'(cnt);
      owed_powers.push_back(r);
      clear_segment();
    endfunction

    function void check_power(logic [POWER_W-1:0] p, logic [SAMPLE_COUNT_W-1:0] c);
      power_result_t want;
      if (owed_powers.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, power %0d count %0d", $time, p, c);
        return;
      end
      want = owed_powers.pop_front();
      results_checked++;
      if (p !== want.power) begin
        errors++;
        $display("%0t: power mismatch, expected %0d actual %0d", $time, want.power, p);
      end
      if (c !== want.sample_count) begin
        errors++;
        $display("%0t: sample_count mismatch, expected %0d actual %0d",
                 $time, want.sample_count, c);
      end
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_idx_i = '0;
  logic [COEF_W-1:0]          cfg_data_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic signed [SAMPLE_W-1:0] sample_i = '0;
  logic                       last_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic [POWER_W-1:0]         power_o;
  logic [SAMPLE_COUNT_W-1:0]  sample_count_o;

  power_meter_tracker tracker = new();

  bit hold_off_req = 1'b0;
  int burst_left   = 8;
  int walk_level   = 0;
  int samples_sent = 0;
  int coef_sets    = 0;

  bandpass_biquad_cascade_power_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .power_o        (power_o),
    .sample_count_o (sample_count_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Pick a sample of the requested flavor; the walk drifts slowly so the
  // filter sees low-frequency content as well as noise.
  function automatic logic signed [SAMPLE_W-1:0] next_sample(sample_kind_e kind);
    int v;
    case (kind)
      SMP_FULL:    v = int'($urandom_range(0, 65535)) - 32768;
      SMP_SMALL:   v = int'($urandom_range(0, 511)) - 256;
      SMP_EXTREME: v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
      default: begin
        walk_level = walk_level + int'($urandom_range(0, 2047)) - 1024;
        if (walk_level > 32767) walk_level = 32767;
        if (walk_level < -32768) walk_level = -32768;
        v = walk_level;
      end
    endcase
    return SAMPLE_W'(v);
  endfunction

  // Write one register; the core takes it on the edge where the enable is high.
  task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.write_coef(idx, val);
  endtask

  task automatic load_coefs(input logic [COEF_W-1:0] b0, input logic [COEF_W-1:0] a1,
                            input logic [COEF_W-1:0] a2);
    write_coef(CFG_B0, b0);
    write_coef(CFG_A1, a1);
    write_coef(CFG_A2, a2);
    coef_sets++;
  endtask

  // Offer one sample and hold it until the transfer. Valid stays high on
  // return so a following sample goes out back to back.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic lst);
    in_valid_i <= 1'b1;
    sample_i   <= s;
    last_i     <= lst;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_sample(s, lst);
    samples_sent++;
  endtask

  // Burst pacing: at the end of a burst drop valid for a random gap, with junk
  // on the payload, then start a new burst.
  task automatic pace_sender();
    int gap;
    burst_left--;
    if (burst_left > 0) return;
    gap = $urandom_range(0, 20);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      sample_i   <= SAMPLE_W'($urandom);
      last_i     <= 1'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    burst_left = $urandom_range(1, 24);
  endtask

  // Drop valid, wait for every owed result, then give the core time to finish
  // a sample that closes no segment.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.owed() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Random segments of random content; mostly well-formed, now and then a
  // stray last flag cuts one short, and a few run several times longer.
  task automatic run_segments(input int n_items, input int max_len);
    int           sent;
    int           len;
    logic         lst;
    sample_kind_e kind;
    sent = 0;
    while (sent < n_items) begin
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(max_len, 3 * max_len)
                                         : $urandom_range(1, max_len);
      kind = sample_kind_e'($urandom_range(0, 3));
      for (int i = 0; i < len; i++) begin
        lst = (i == len - 1) || ($urandom_range(0, 49) == 0);
        send_sample(next_sample(kind), lst);
        pace_sender();
        sent++;
      end
    end
  endtask

  // One segment that never raises last; it must close on its own count.
  task automatic run_overlong();
    for (int i = 0; i < MAX_SEGMENT; i++) begin
      send_sample(next_sample(sample_kind_e'($urandom_range(0, 3))), 1'b0);
      pace_sender();
    end
  endtask

  // Receiver: switch to a random stall pattern after a random stretch, and honor
  // a request for one long hold-off.
  initial begin
    rx_mode_e   mode;
    int         left;
    logic [7:0] mask;
    mode = RX_OPEN;
    left = 0;
    mask = 8'h5A;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        if (left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 3));
          mask = 8'($urandom_range(1, 255));
          left = $urandom_range(16, 96);
        end
        left--;
        case (mode)
          RX_OPEN:   out_ready_i <= 1'b1;
          RX_RANDOM: out_ready_i <= ($urandom_range(0, 3) != 0);
          RX_PATTERN: begin
            out_ready_i <= mask[0];
            mask = {mask[0], mask[7:1]};
          end
          default:   out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Check every result transfer against the oldest owed power.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) tracker.check_power(power_o, sample_count_o);
  end

  // Watchdog: end the run if no transfer happens on either side for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: watchdog expired after %0d idle cycles", $time, WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Coefficients still at reset: the output must be zero power.
    send_sample(16'sd100, 1'b1);
    settle();

    // Realistic band-pass; full-scale swings, sign edges, a one-sample segment,
    // and a write to the unused index that must change nothing.
    load_coefs(BP_B0, BP_A1, BP_A2);
    write_coef(CFG_UNUSED, 32'hFFFF_FFFF);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd32767, 1'b1);
    send_sample(-16'sd32768, 1'b1);
    settle();

    // Extreme coefficients: saturate every section, the square sum and power.
    load_coefs(COEF_MAX, COEF_MIN, COEF_MAX);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd12345, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd0, 1'b1);
    settle();

    // Most negative gain with no feedback.
    load_coefs(COEF_MIN, COEF_ZERO, COEF_ZERO);
    send_sample(-16'sd32768, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(16'sd32767, 1'b1);
    settle();

    load_coefs(BP_B0, BP_A1, BP_A2);
    run_segments(100, 16);
    settle();

    // Random coefficients with very short segments; hold the receiver off so
    // results back up and the core stops taking samples.
    load_coefs($urandom, $urandom, $urandom);
    hold_off_req = 1'b1;
    run_segments(100, 2);
    settle();

    load_coefs(COEF_MIN, COEF_MAX, COEF_MIN);
    run_segments(60, 8);
    settle();

    // Narrow band with a random small gain; includes the self-closing segment.
    load_coefs(COEF_W'($urandom_range(0, 32'h00FF_FFFF)), NB_A1, NB_A2);
    run_overlong();
    run_segments(100, 16);
    settle();

    load_coefs(COEF_ZERO, $urandom, $urandom);
    run_segments(60, 12);
    settle();

    load_coefs($urandom, $urandom, $urandom);
    write_coef(CFG_UNUSED, $urandom);
    run_segments(100, 16);
    settle();

    $display("Sent %0d samples under %0d coefficient sets; checked %0d power results.",
             samples_sent, coef_sets, tracker.results_checked);
    $display("Covered saturation, a self-closing full-length segment and output backpressure.");
    if (tracker.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== bandpass_biquad_cascade_power_core.f =====
rtl/bpbq_pkg.sv
rtl/bpbq_div.sv
rtl/bandpass_biquad_cascade_power_core.sv
dv/tb_bandpass_biquad_cascade_power_core.sv
